// ----- hdl/tmhq_pkg.sv -----
// package with shared types and codes of the timer min-heap queue
package tmhq_pkg;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DEC, ST_INS_H, ST_RM_P, ST_EX_H, ST_EX_D, ST_REM, ST_RM_L,
    ST_UP, ST_UP_C, ST_DN, ST_DN_A, ST_DN_B, ST_DN_C, ST_PLACE, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_FULL         = 3'd1;
  localparam logic [2:0] STS_BAD_HANDLE   = 3'd2;
  localparam logic [2:0] STS_NOT_FUTURE   = 3'd3;
  localparam logic [2:0] STS_BAD_CALLBACK = 3'd4;
  localparam logic [2:0] STS_NOTHING_DUE  = 3'd5;

  typedef struct packed {
    logic    clr_done;
    logic    dec_err;
    opcode_e op;
    logic    pos_zero;
    logic    rm_last;
    logic    up_root;
    logic    up_stop;
    logic    dn_leaf;
    logic    dn_right;
    logic    dn_stop;
    logic    out_busy;
  } dp_sts_t;

endpackage

// ----- hdl/tmhq_ram.sv -----
// generic single write, single read ram with registered read data
module tmhq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/tmhq_ctrl.sv -----
// controller state machine of the timer min-heap queue
module tmhq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tmhq_pkg::dp_sts_t sts_i,
  output tmhq_pkg::state_e  cmd_o
);

  tmhq_pkg::state_e state_q, state_d;
  logic ins;

  assign ins        = (sts_i.op == tmhq_pkg::OP_INSERT);
  assign cmd_o      = state_q;
  assign in_ready_o = (state_q == tmhq_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmhq_pkg::ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmhq_pkg::ST_CLR:   if (sts_i.clr_done) state_d = tmhq_pkg::ST_IDLE;
      tmhq_pkg::ST_IDLE:  if (in_valid_i) state_d = tmhq_pkg::ST_DEC;
      tmhq_pkg::ST_DEC: begin
        if (sts_i.dec_err) begin
          state_d = tmhq_pkg::ST_FIN;
        end else begin
          unique case (sts_i.op)
            tmhq_pkg::OP_INSERT: state_d = tmhq_pkg::ST_INS_H;
            tmhq_pkg::OP_REMOVE: state_d = tmhq_pkg::ST_RM_P;
            tmhq_pkg::OP_EXPIRE: state_d = tmhq_pkg::ST_EX_H;
            default:             state_d = tmhq_pkg::ST_FIN;
          endcase
        end
      end
      tmhq_pkg::ST_INS_H: state_d = tmhq_pkg::ST_UP;
      tmhq_pkg::ST_RM_P:  state_d = sts_i.pos_zero ? tmhq_pkg::ST_FIN : tmhq_pkg::ST_REM;
      tmhq_pkg::ST_EX_H:  state_d = tmhq_pkg::ST_EX_D;
      tmhq_pkg::ST_EX_D:  state_d = tmhq_pkg::ST_REM;
      tmhq_pkg::ST_REM:   state_d = sts_i.rm_last ? tmhq_pkg::ST_FIN : tmhq_pkg::ST_RM_L;
      tmhq_pkg::ST_RM_L:  state_d = tmhq_pkg::ST_UP;
      tmhq_pkg::ST_UP: begin
        if (sts_i.up_root) begin
          state_d = ins ? tmhq_pkg::ST_PLACE : tmhq_pkg::ST_DN;
        end else begin
          state_d = tmhq_pkg::ST_UP_C;
        end
      end
      tmhq_pkg::ST_UP_C: begin
        if (sts_i.up_stop) begin
          state_d = ins ? tmhq_pkg::ST_PLACE : tmhq_pkg::ST_DN;
        end else begin
          state_d = tmhq_pkg::ST_UP;
        end
      end
      tmhq_pkg::ST_DN:    state_d = sts_i.dn_leaf ? tmhq_pkg::ST_PLACE : tmhq_pkg::ST_DN_A;
      tmhq_pkg::ST_DN_A:  state_d = sts_i.dn_right ? tmhq_pkg::ST_DN_B : tmhq_pkg::ST_DN_C;
      tmhq_pkg::ST_DN_B:  state_d = tmhq_pkg::ST_DN_C;
      tmhq_pkg::ST_DN_C:  state_d = sts_i.dn_stop ? tmhq_pkg::ST_PLACE : tmhq_pkg::ST_DN;
      tmhq_pkg::ST_PLACE: state_d = tmhq_pkg::ST_FIN;
      tmhq_pkg::ST_FIN:   if (!sts_i.out_busy) state_d = tmhq_pkg::ST_IDLE;
      default:            state_d = tmhq_pkg::ST_CLR;
    endcase
  end

  a_dec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmhq_pkg::ST_IDLE && in_valid_i) |=> (state_q == tmhq_pkg::ST_DEC))
    else $error("accepted item not decoded");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmhq_pkg::ST_FIN && sts_i.out_busy) |=> (state_q == tmhq_pkg::ST_FIN))
    else $error("result dropped while output busy");
  a_place_from_sift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmhq_pkg::ST_PLACE) |-> ($past(state_q) == tmhq_pkg::ST_UP ||
      $past(state_q) == tmhq_pkg::ST_UP_C || $past(state_q) == tmhq_pkg::ST_DN ||
      $past(state_q) == tmhq_pkg::ST_DN_C))
    else $error("place without sift");

endmodule

// ----- hdl/tmhq_dp.sv -----
// datapath of the timer min-heap queue: heap memories, handle table, free stack
module tmhq_dp #(
  parameter int HEAP_CAPACITY  = 1024,
  parameter int CALLBACK_SLOTS = 8,
  parameter int TIME_BITS      = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tmhq_pkg::state_e        cmd_i,
  output tmhq_pkg::dp_sts_t       sts_o,
  input  logic                    cfg_we_i,
  input  logic [3:0]              cfg_wdata_i,
  input  logic                    accept_i,
  input  logic [1:0]              opcode_i,
  input  logic [TIME_BITS-1:0]    current_time_i,
  input  logic [TIME_BITS-1:0]    wakeup_time_i,
  input  logic [2:0]              callback_id_i,
  input  logic signed [31:0]      extra_word_i,
  input  logic [9:0]              handle_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [9:0]              result_handle_o,
  output logic [2:0]              fired_callback_o,
  output logic signed [31:0]      fired_extra_o,
  output logic [10:0]             pending_count_o,
  output logic [TIME_BITS-1:0]    earliest_time_o,
  output logic                    earliest_valid_o
);

  localparam int HB = $clog2(HEAP_CAPACITY);
  localparam int PB = $clog2(HEAP_CAPACITY + 1);

  logic [3:0]           cfg_q;
  tmhq_pkg::opcode_e    op_q;
  logic [TIME_BITS-1:0] now_q, wake_q, top_q, t_q, ch_t_q;
  logic [2:0]           cb_q, fcb_q;
  logic [31:0]          ex_q, fex_q;
  logic [9:0]           hin_q;
  logic [HB-1:0]        h_q, rm_h_q, ch_h_q, rh_q, clr_q;
  logic [PB-1:0]        cnt_q, fcnt_q, i_q;
  logic [PB:0]          j_q, i2;
  logic [2:0]           st_q, dec_st;
  logic                 out_valid_q, out_busy;

  logic                 ord_we, psm_we, fsm_we, wr_ins;
  logic [HB-1:0]        ord_wa, psm_wa, fsm_wa, hp_ra;
  logic [HB-1:0]        ord_wd, fsm_wd;
  logic [PB-1:0]        psm_wd;
  logic [TIME_BITS-1:0] htm_wd;
  logic [HB-1:0]        ord_rd, fsm_rd;
  logic [PB-1:0]        psm_rd;
  logic [TIME_BITS-1:0] htm_rd;
  logic [2:0]           cbm_rd;
  logic [31:0]          exm_rd;
  logic [6:0]           lim;

  assign i2       = {i_q, 1'b0};
  assign out_busy = out_valid_q && !out_ready_i;
  assign lim      = (7'(cfg_q) < 7'(CALLBACK_SLOTS)) ? 7'(cfg_q) : 7'(CALLBACK_SLOTS);

  always_comb begin
    dec_st = tmhq_pkg::STS_OK;
    case (op_q)
      tmhq_pkg::OP_INSERT: begin
        if (7'(cb_q) >= lim) begin
          dec_st = tmhq_pkg::STS_BAD_CALLBACK;
        end else if (wake_q <= now_q) begin
          dec_st = tmhq_pkg::STS_NOT_FUTURE;
        end else if (fcnt_q == '0 || 32'(cnt_q) >= 32'(HEAP_CAPACITY)) begin
          dec_st = tmhq_pkg::STS_FULL;
        end
      end
      tmhq_pkg::OP_REMOVE: begin
        if (32'(hin_q) >= 32'(HEAP_CAPACITY)) dec_st = tmhq_pkg::STS_BAD_HANDLE;
      end
      tmhq_pkg::OP_EXPIRE: begin
        if (cnt_q == '0 || top_q > now_q) dec_st = tmhq_pkg::STS_NOTHING_DUE;
      end
      default: dec_st = tmhq_pkg::STS_NOTHING_DUE;
    endcase
  end

  always_comb begin
    sts_o.clr_done = (32'(clr_q) == HEAP_CAPACITY - 1);
    sts_o.dec_err  = (dec_st != tmhq_pkg::STS_OK);
    sts_o.op       = op_q;
    sts_o.pos_zero = (psm_rd == '0);
    sts_o.rm_last  = (i_q == cnt_q);
    sts_o.up_root  = (i_q == PB'(1));
    sts_o.up_stop  = (htm_rd <= t_q);
    sts_o.dn_leaf  = (i2 > (PB+1)'(cnt_q));
    sts_o.dn_right = (j_q < (PB+1)'(cnt_q));
    sts_o.dn_stop  = (t_q <= ch_t_q);
    sts_o.out_busy = out_busy;
  end

  // read address of heap order and heap time
  always_comb begin
    hp_ra = '0;
    case (cmd_i)
      tmhq_pkg::ST_REM:  hp_ra = HB'(cnt_q - PB'(1));
      tmhq_pkg::ST_UP:   hp_ra = HB'((i_q >> 1) - PB'(1));
      tmhq_pkg::ST_DN:   hp_ra = HB'(i2 - (PB+1)'(1));
      tmhq_pkg::ST_DN_A: hp_ra = HB'(j_q);
      default:           hp_ra = '0;
    endcase
  end

  // write ports
  always_comb begin
    ord_we = 1'b0; ord_wa = HB'(i_q - PB'(1)); ord_wd = h_q; htm_wd = t_q;
    psm_we = 1'b0; psm_wa = h_q; psm_wd = i_q;
    fsm_we = 1'b0; fsm_wa = HB'(fcnt_q); fsm_wd = rm_h_q;
    wr_ins = 1'b0;
    case (cmd_i)
      tmhq_pkg::ST_CLR: begin
        psm_we = 1'b1; psm_wa = clr_q; psm_wd = '0;
        fsm_we = 1'b1; fsm_wa = clr_q; fsm_wd = clr_q;
      end
      tmhq_pkg::ST_INS_H: wr_ins = 1'b1;
      tmhq_pkg::ST_REM: begin
        psm_we = 1'b1; psm_wa = rm_h_q; psm_wd = '0;
        fsm_we = 1'b1;
      end
      tmhq_pkg::ST_UP_C: begin
        if (!(htm_rd <= t_q)) begin
          ord_we = 1'b1; ord_wd = ord_rd; htm_wd = htm_rd;
          psm_we = 1'b1; psm_wa = ord_rd;
        end
      end
      tmhq_pkg::ST_DN_C: begin
        if (!(t_q <= ch_t_q)) begin
          ord_we = 1'b1; ord_wd = ch_h_q; htm_wd = ch_t_q;
          psm_we = 1'b1; psm_wa = ch_h_q;
        end
      end
      tmhq_pkg::ST_PLACE: begin
        ord_we = 1'b1;
        psm_we = 1'b1;
      end
      default: ;
    endcase
  end

  tmhq_ram #(.W(HB), .D(HEAP_CAPACITY)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd), .raddr_i(hp_ra),
    .rdata_o(ord_rd));
  tmhq_ram #(.W(TIME_BITS), .D(HEAP_CAPACITY)) u_htm (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(htm_wd), .raddr_i(hp_ra),
    .rdata_o(htm_rd));
  tmhq_ram #(.W(3), .D(HEAP_CAPACITY)) u_cbm (
    .clk_i, .we_i(wr_ins), .waddr_i(fsm_rd), .wdata_i(cb_q), .raddr_i(ord_rd),
    .rdata_o(cbm_rd));
  tmhq_ram #(.W(32), .D(HEAP_CAPACITY)) u_exm (
    .clk_i, .we_i(wr_ins), .waddr_i(fsm_rd), .wdata_i(ex_q), .raddr_i(ord_rd),
    .rdata_o(exm_rd));
  tmhq_ram #(.W(PB), .D(HEAP_CAPACITY)) u_psm (
    .clk_i, .we_i(psm_we), .waddr_i(psm_wa), .wdata_i(psm_wd), .raddr_i(HB'(hin_q)),
    .rdata_o(psm_rd));
  tmhq_ram #(.W(HB), .D(HEAP_CAPACITY)) u_fsm (
    .clk_i, .we_i(fsm_we), .waddr_i(fsm_wa), .wdata_i(fsm_wd),
    .raddr_i(HB'(fcnt_q - PB'(1))), .rdata_o(fsm_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      cnt_q       <= '0;
      fcnt_q      <= PB'(HEAP_CAPACITY);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (cmd_i == tmhq_pkg::ST_CLR) clr_q <= clr_q + HB'(1);
      if (cmd_i == tmhq_pkg::ST_DEC && op_q == tmhq_pkg::OP_INSERT &&
          dec_st == tmhq_pkg::STS_OK) begin
        cnt_q  <= cnt_q + PB'(1);
        fcnt_q <= fcnt_q - PB'(1);
      end
      if (cmd_i == tmhq_pkg::ST_REM) begin
        cnt_q  <= cnt_q - PB'(1);
        fcnt_q <= fcnt_q + PB'(1);
      end
      if (cmd_i == tmhq_pkg::ST_FIN && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q   <= tmhq_pkg::opcode_e'(opcode_i);
      now_q  <= current_time_i;
      wake_q <= wakeup_time_i;
      cb_q   <= callback_id_i;
      ex_q   <= extra_word_i;
      hin_q  <= handle_i;
    end
    case (cmd_i)
      tmhq_pkg::ST_DEC: begin
        st_q  <= dec_st;
        rh_q  <= (op_q != tmhq_pkg::OP_REMOVE || dec_st != tmhq_pkg::STS_OK) ?
                 '0 : HB'(hin_q);
        rm_h_q <= HB'(hin_q);
        fcb_q <= '0;
        fex_q <= '0;
        i_q   <= (op_q == tmhq_pkg::OP_INSERT) ? cnt_q + PB'(1) : PB'(1);
        t_q   <= wake_q;
      end
      tmhq_pkg::ST_INS_H: begin
        h_q  <= fsm_rd;
        rh_q <= fsm_rd;
      end
      tmhq_pkg::ST_RM_P: begin
        i_q <= psm_rd;
        if (psm_rd == '0) begin
          st_q <= tmhq_pkg::STS_BAD_HANDLE;
          rh_q <= '0;
        end
      end
      tmhq_pkg::ST_EX_H: begin
        rm_h_q <= ord_rd;
        rh_q   <= ord_rd;
      end
      tmhq_pkg::ST_EX_D: begin
        fcb_q <= cbm_rd;
        fex_q <= exm_rd;
      end
      tmhq_pkg::ST_RM_L: begin
        h_q <= ord_rd;
        t_q <= htm_rd;
      end
      tmhq_pkg::ST_UP_C: begin
        if (!(htm_rd <= t_q)) i_q <= i_q >> 1;
      end
      tmhq_pkg::ST_DN: j_q <= i2;
      tmhq_pkg::ST_DN_A: begin
        ch_h_q <= ord_rd;
        ch_t_q <= htm_rd;
      end
      tmhq_pkg::ST_DN_B: begin
        if (ch_t_q > htm_rd) begin
          ch_h_q <= ord_rd;
          ch_t_q <= htm_rd;
          j_q    <= j_q + (PB+1)'(1);
        end
      end
      tmhq_pkg::ST_DN_C: begin
        if (!(t_q <= ch_t_q)) begin
          if (i_q == PB'(1)) top_q <= ch_t_q;
          i_q <= PB'(j_q);
        end
      end
      tmhq_pkg::ST_PLACE: begin
        if (i_q == PB'(1)) top_q <= t_q;
      end
      tmhq_pkg::ST_FIN: begin
        if (!out_busy) begin
          status_o         <= st_q;
          result_handle_o  <= 10'(rh_q);
          fired_callback_o <= fcb_q;
          fired_extra_o    <= fex_q;
          pending_count_o  <= 11'(cnt_q);
          earliest_time_o  <= (cnt_q != '0) ? top_q : '0;
          earliest_valid_o <= (cnt_q != '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((PB+1)'(cnt_q) + (PB+1)'(fcnt_q)) == (PB+1)'(HEAP_CAPACITY))
    else $error("handles lost between heap and free stack");
  a_place_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == tmhq_pkg::ST_PLACE) |-> (i_q != '0 && i_q <= cnt_q))
    else $error("place outside heap");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o != tmhq_pkg::STS_OK) |->
      (result_handle_o == '0 && fired_callback_o == '0 && fired_extra_o == '0))
    else $error("error result carries data");

endmodule

// ----- hdl/timer_min_heap_queue_core.sv -----
// top level of the timer min-heap queue
// Timer queue kept as a binary min-heap of wakeup times with a handle table and a
// free handle stack. After reset a clearing pass over all HEAP_CAPACITY entries
// (1024 by default) initializes the handle table and free stack; no item is
// accepted until it ends. Items are processed one at a time: an insert sifts the
// new entry up the heap, while a remove or an expire moves the last heap entry into
// the freed slot, unless it was that entry, and sifts it up and then down. Results
// sit in an output register so the next item is accepted while a result waits to
// be taken.
module timer_min_heap_queue_core #(
  parameter int HEAP_CAPACITY  = 1024,
  parameter int CALLBACK_SLOTS = 8,
  parameter int TIME_BITS      = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  logic [TIME_BITS-1:0] current_time_i,
  input  logic [TIME_BITS-1:0] wakeup_time_i,
  input  logic [2:0]           callback_id_i,
  input  logic signed [31:0]   extra_word_i,
  input  logic [9:0]           handle_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [9:0]           result_handle_o,
  output logic [2:0]           fired_callback_o,
  output logic signed [31:0]   fired_extra_o,
  output logic [10:0]          pending_count_o,
  output logic [TIME_BITS-1:0] earliest_time_o,
  output logic                 earliest_valid_o
);

  tmhq_pkg::state_e  cmd;
  tmhq_pkg::dp_sts_t sts;

  tmhq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd));

  tmhq_dp #(
    .HEAP_CAPACITY(HEAP_CAPACITY), .CALLBACK_SLOTS(CALLBACK_SLOTS), .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_wdata_i,
    .accept_i(in_valid_i && in_ready_o), .opcode_i, .current_time_i, .wakeup_time_i,
    .callback_id_i, .extra_word_i, .handle_i, .out_valid_o, .out_ready_i, .status_o,
    .result_handle_o, .fired_callback_o, .fired_extra_o, .pending_count_o,
    .earliest_time_o, .earliest_valid_o);

endmodule
